@@ rtl/axis_range_rounding_top_defines.svh @@
// assertion macros used by the axis range rounding controller
`ifndef AXIS_RANGE_ROUNDING_TOP_DEFINES_SVH
`define AXIS_RANGE_ROUNDING_TOP_DEFINES_SVH

// same-cycle implication under active-low reset
`define ARR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("axis range rounding: implication failed");

// next-cycle implication under active-low reset
`define ARR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("axis range rounding: next-cycle check failed");

`endif

@@ rtl/arr_pkg.sv @@
// shared constants, command and status types of the axis range rounding block
package arr_pkg;

  localparam int VW          = 48;
  localparam int FRAC_DIGITS = 6;
  localparam int SW          = VW + 2;
  localparam int DIV_CHUNK   = 8;
  localparam int DIV_STEPS   = 7;
  localparam int MW          = DIV_CHUNK * DIV_STEPS;
  localparam int STW         = $clog2(DIV_STEPS);
  localparam int CW          = 5;
  localparam int PW          = 3;

  localparam logic [MW-1:0] POS_LIM = MW'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic [MW-1:0] NEG_LIM = MW'(64'd1 << (VW - 1));

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_TAKE,
    OP_MARGIN,
    OP_OFFSET,
    OP_BOUND,
    OP_SCALE_INIT,
    OP_SCALE_STEP,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   bsel;
    logic   use_new;
  } dp_cmd_t;

  typedef struct packed {
    logic          div_busy;
    logic          div_done;
    logic          quot_eq;
    logic          zero_bound;
    logic [PW-1:0] down_exp;
  } dp_sts_t;

endpackage

@@ rtl/arr_div10.sv @@
// two-lane divide-by-ten unit, eight quotient bits per cycle
module arr_div10 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [arr_pkg::MW-1:0]   a_i,
  input  logic [arr_pkg::MW-1:0]   b_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [arr_pkg::MW-1:0]   qa_o,
  output logic [arr_pkg::MW-1:0]   qb_o
);

  logic [arr_pkg::MW-1:0]        xa_q, xa_d, xb_q, xb_d;
  logic [3:0]                    ra_q, ra_d, rb_q, rb_d;
  logic [arr_pkg::STW-1:0]       step_q, step_d;
  logic                          busy_q, busy_d, done_q, done_d;
  logic [arr_pkg::DIV_CHUNK+3:0] ca, cb;

  function automatic logic [arr_pkg::DIV_CHUNK+3:0] chunk_div(
    input logic [3:0]                    rem,
    input logic [arr_pkg::DIV_CHUNK-1:0] bits
  );
    logic [4:0]                    acc;
    logic [3:0]                    r;
    logic [arr_pkg::DIV_CHUNK-1:0] q;
    r = rem;
    q = '0;
    for (int i = arr_pkg::DIV_CHUNK - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= 5'd10) begin
        q[i] = 1'b1;
        r    = 4'(acc - 5'd10);
      end else begin
        q[i] = 1'b0;
        r    = acc[3:0];
      end
    end
    return {r, q};
  endfunction

  always_comb begin
    ca     = chunk_div(ra_q, xa_q[arr_pkg::MW-1 -: arr_pkg::DIV_CHUNK]);
    cb     = chunk_div(rb_q, xb_q[arr_pkg::MW-1 -: arr_pkg::DIV_CHUNK]);
    xa_d   = xa_q;
    xb_d   = xb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      xa_d   = a_i;
      xb_d   = b_i;
      ra_d   = '0;
      rb_d   = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      xa_d   = {xa_q[arr_pkg::MW-arr_pkg::DIV_CHUNK-1:0], ca[arr_pkg::DIV_CHUNK-1:0]};
      xb_d   = {xb_q[arr_pkg::MW-arr_pkg::DIV_CHUNK-1:0], cb[arr_pkg::DIV_CHUNK-1:0]};
      ra_d   = ca[arr_pkg::DIV_CHUNK+3:arr_pkg::DIV_CHUNK];
      rb_d   = cb[arr_pkg::DIV_CHUNK+3:arr_pkg::DIV_CHUNK];
      step_d = step_q + 1'b1;
      if (step_q == arr_pkg::STW'(arr_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q <= xa_d;
    xb_q <= xb_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign qa_o   = xa_q;
  assign qb_o   = xb_q;

endmodule

@@ rtl/arr_dp.sv @@
// datapath: scaling, margin, decade search and rescaling registers
module arr_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [arr_pkg::VW-1:0]   lower_in_i,
  input  logic signed [arr_pkg::VW-1:0]   upper_in_i,
  input  logic [arr_pkg::PW-1:0]          precision_i,
  input  arr_pkg::dp_cmd_t                cmd_i,
  output arr_pkg::dp_sts_t                sts_o,
  output logic signed [arr_pkg::VW-1:0]   lower_out_o,
  output logic signed [arr_pkg::VW-1:0]   upper_out_o,
  output logic                            saturated_o
);

  logic                          sa_q, sb_q;
  logic [arr_pkg::MW-1:0]        ma_q, mb_q, v_q;
  logic [arr_pkg::PW-1:0]        nd_q;
  logic signed [arr_pkg::SW-1:0] lmin_q, lmax_q, off_q;
  logic                          sd_q, zero_q, neg_q, adj_q, sat_q;
  logic [arr_pkg::VW-1:0]        lower_q, upper_q;

  logic                          div_busy, div_done;
  logic [arr_pkg::MW-1:0]        qa, qb;
  logic [arr_pkg::MW-1:0]        lo_x, hi_x, lo_mag, hi_mag;
  logic [arr_pkg::PW-1:0]        p_clamp, nd_c;
  logic signed [arr_pkg::SW-1:0] lmin_c, lmax_c, diff_c, l_sel, t_sel;
  logic                          zero_c, neg_c;
  logic [arr_pkg::MW-1:0]        lim, r_c, r_neg;
  logic                          over;
  logic [arr_pkg::VW-1:0]        store_val;

  function automatic logic [arr_pkg::MW-1:0] mag_of(input logic signed [arr_pkg::SW-1:0] v);
    logic signed [arr_pkg::SW-1:0] n;
    n = v[arr_pkg::SW-1] ? -v : v;
    return arr_pkg::MW'(unsigned'(n));
  endfunction

  arr_div10 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == arr_pkg::OP_DIV_START),
    .a_i     (ma_q),
    .b_i     (mb_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .qa_o    (qa),
    .qb_o    (qb)
  );

  always_comb begin
    lo_x    = {{(arr_pkg::MW - arr_pkg::VW){lower_in_i[arr_pkg::VW-1]}}, lower_in_i};
    hi_x    = {{(arr_pkg::MW - arr_pkg::VW){upper_in_i[arr_pkg::VW-1]}}, upper_in_i};
    lo_mag  = lower_in_i[arr_pkg::VW-1] ? (~lo_x + 1'b1) : lo_x;
    hi_mag  = upper_in_i[arr_pkg::VW-1] ? (~hi_x + 1'b1) : hi_x;
    p_clamp = (precision_i > arr_pkg::PW'(arr_pkg::FRAC_DIGITS))
              ? arr_pkg::PW'(arr_pkg::FRAC_DIGITS) : precision_i;
    nd_c    = arr_pkg::PW'(arr_pkg::FRAC_DIGITS) - p_clamp;

    lmin_c  = sa_q ? -$signed(ma_q[arr_pkg::SW-1:0]) : $signed(ma_q[arr_pkg::SW-1:0]);
    lmax_c  = sb_q ? -$signed(mb_q[arr_pkg::SW-1:0]) : $signed(mb_q[arr_pkg::SW-1:0]);
    diff_c  = lmax_c - lmin_c;

    l_sel   = cmd_i.bsel ? lmax_q : lmin_q;
    t_sel   = cmd_i.bsel ? (lmax_q + off_q) : (lmin_q - off_q);
    if (cmd_i.bsel) begin
      // upper: forced to zero when the margin lifts a non-positive max to zero or above
      zero_c = (l_sel[arr_pkg::SW-1] || l_sel == '0) && !t_sel[arr_pkg::SW-1];
      neg_c  = l_sel[arr_pkg::SW-1] || l_sel == '0;
    end else begin
      zero_c = (t_sel[arr_pkg::SW-1] || t_sel == '0) && !l_sel[arr_pkg::SW-1];
      neg_c  = l_sel[arr_pkg::SW-1];
    end

    lim       = neg_q ? arr_pkg::NEG_LIM : arr_pkg::POS_LIM;
    over      = v_q > lim;
    r_c       = over ? lim : v_q;
    r_neg     = neg_q ? (~r_c + 1'b1) : r_c;
    store_val = zero_q ? '0 : r_neg[arr_pkg::VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      arr_pkg::OP_LOAD: begin
        sa_q  <= lower_in_i[arr_pkg::VW-1];
        sb_q  <= upper_in_i[arr_pkg::VW-1];
        ma_q  <= lo_mag;
        mb_q  <= hi_mag;
        nd_q  <= nd_c;
        sat_q <= 1'b0;
      end
      arr_pkg::OP_DIV_TAKE: begin
        ma_q <= qa;
        mb_q <= qb;
      end
      arr_pkg::OP_MARGIN: begin
        lmin_q <= lmin_c;
        lmax_q <= lmax_c;
        sd_q   <= diff_c[arr_pkg::SW-1];
        ma_q   <= mag_of(diff_c);
      end
      arr_pkg::OP_OFFSET: begin
        off_q <= sd_q ? -$signed(ma_q[arr_pkg::SW-1:0]) : $signed(ma_q[arr_pkg::SW-1:0]);
      end
      arr_pkg::OP_BOUND: begin
        sa_q   <= t_sel[arr_pkg::SW-1];
        ma_q   <= mag_of(t_sel);
        sb_q   <= l_sel[arr_pkg::SW-1];
        mb_q   <= mag_of(l_sel);
        zero_q <= zero_c;
        neg_q  <= neg_c;
        adj_q  <= cmd_i.bsel ? !neg_c : neg_c;
      end
      arr_pkg::OP_SCALE_INIT: begin
        v_q <= (cmd_i.use_new ? qb : mb_q) + arr_pkg::MW'(adj_q);
      end
      arr_pkg::OP_SCALE_STEP: begin
        if (!over) begin
          v_q <= (v_q << 3) + (v_q << 1);
        end
      end
      arr_pkg::OP_STORE: begin
        sat_q <= sat_q | (!zero_q && over);
        if (cmd_i.bsel) begin
          upper_q <= store_val;
        end else begin
          lower_q <= store_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.quot_eq    = (qa == '0 && qb == '0) || (sa_q == sb_q && qa == qb);
  assign sts_o.zero_bound = zero_q;
  assign sts_o.down_exp   = nd_q;

  assign lower_out_o = $signed(lower_q);
  assign upper_out_o = $signed(upper_q);
  assign saturated_o = sat_q;

endmodule

@@ rtl/arr_ctrl.sv @@
// controller state machine sequencing the datapath
`include "axis_range_rounding_top_defines.svh"

module arr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  arr_pkg::dp_sts_t sts_i,
  output arr_pkg::dp_cmd_t cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRUNC_CHK,
    S_TRUNC_WAIT,
    S_MARGIN,
    S_DIFF_START,
    S_DIFF_WAIT,
    S_OFFSET,
    S_BOUND,
    S_ZERO_CHK,
    S_ALIGN_START,
    S_ALIGN_WAIT,
    S_SCALE,
    S_STORE
  } state_e;

  state_e                 state_q, state_d;
  logic [arr_pkg::CW-1:0] cnt_q, cnt_d, knew;
  logic                   bsel_q, bsel_d, done_q, done_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    bsel_d        = bsel_q;
    done_d        = 1'b0;
    knew          = cnt_q + 1'b1;
    cmd_o.op      = arr_pkg::OP_NONE;
    cmd_o.bsel    = bsel_q;
    cmd_o.use_new = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = arr_pkg::OP_LOAD;
          cnt_d    = '0;
          bsel_d   = 1'b0;
          state_d  = S_TRUNC_CHK;
        end
      end
      S_TRUNC_CHK: begin
        if (cnt_q == arr_pkg::CW'(sts_i.down_exp)) begin
          state_d = S_MARGIN;
        end else begin
          cmd_o.op = arr_pkg::OP_DIV_START;
          state_d  = S_TRUNC_WAIT;
        end
      end
      S_TRUNC_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = arr_pkg::OP_DIV_TAKE;
          cnt_d    = knew;
          state_d  = S_TRUNC_CHK;
        end
      end
      S_MARGIN: begin
        cmd_o.op = arr_pkg::OP_MARGIN;
        state_d  = S_DIFF_START;
      end
      S_DIFF_START: begin
        cmd_o.op = arr_pkg::OP_DIV_START;
        state_d  = S_DIFF_WAIT;
      end
      S_DIFF_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = arr_pkg::OP_DIV_TAKE;
          state_d  = S_OFFSET;
        end
      end
      S_OFFSET: begin
        cmd_o.op = arr_pkg::OP_OFFSET;
        state_d  = S_BOUND;
      end
      S_BOUND: begin
        cmd_o.op = arr_pkg::OP_BOUND;
        state_d  = S_ZERO_CHK;
      end
      S_ZERO_CHK: begin
        if (sts_i.zero_bound) begin
          state_d = S_STORE;
        end else begin
          cmd_o.op = arr_pkg::OP_DIV_START;
          cnt_d    = '0;
          state_d  = S_ALIGN_WAIT;
        end
      end
      S_ALIGN_START: begin
        cmd_o.op = arr_pkg::OP_DIV_START;
        state_d  = S_ALIGN_WAIT;
      end
      S_ALIGN_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.quot_eq) begin
            // coarsest differing decade, ten when the first one already agrees
            cmd_o.op      = arr_pkg::OP_SCALE_INIT;
            cmd_o.use_new = (knew == arr_pkg::CW'(1));
            cnt_d         = ((knew == arr_pkg::CW'(1)) ? knew : cnt_q)
                            + arr_pkg::CW'(sts_i.down_exp);
            state_d       = S_SCALE;
          end else begin
            cmd_o.op = arr_pkg::OP_DIV_TAKE;
            cnt_d    = knew;
            state_d  = S_ALIGN_START;
          end
        end
      end
      S_SCALE: begin
        if (cnt_q == '0) begin
          state_d = S_STORE;
        end else begin
          cmd_o.op = arr_pkg::OP_SCALE_STEP;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      S_STORE: begin
        cmd_o.op = arr_pkg::OP_STORE;
        if (!bsel_q) begin
          bsel_d  = 1'b1;
          state_d = S_BOUND;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      bsel_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bsel_q  <= bsel_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `ARR_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, done_q, !done_q)
  `ARR_ASSERT_IMP(a_div_free_on_start, clk_i, rst_ni, cmd_o.op == arr_pkg::OP_DIV_START, !sts_i.div_busy)
  `ARR_ASSERT_IMP(a_div_done_expected, clk_i, rst_ni, sts_i.div_done, state_q == S_TRUNC_WAIT || state_q == S_DIFF_WAIT || state_q == S_ALIGN_WAIT)

endmodule

@@ rtl/axis_range_rounding_top.sv @@
// top level of the axis range rounding block: controller plus datapath
// n = 6 - min(precision, 6) truncating divisions by ten run first; then per bound, unless the bound is
// forced to zero, d decade divisions (at most 15) and b + n multiplications by ten, with 10^b the step
// each decimal division runs on the shared two-lane divide-by-ten unit
// out_valid_o rises the cycle after the last store
// one item at a time: start is taken only while busy is low; results cannot be stalled
// reset is asynchronous active low and returns the controller to idle with no result pending
module axis_range_rounding_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [arr_pkg::VW-1:0] lower_in_i,
  input  logic signed [arr_pkg::VW-1:0] upper_in_i,
  input  logic [arr_pkg::PW-1:0]        precision_i,
  output logic                          out_valid_o,
  output logic signed [arr_pkg::VW-1:0] lower_out_o,
  output logic signed [arr_pkg::VW-1:0] upper_out_o,
  output logic                          saturated_o
);

  arr_pkg::dp_cmd_t cmd;
  arr_pkg::dp_sts_t sts;

  arr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (out_valid_o)
  );

  arr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lower_in_i  (lower_in_i),
    .upper_in_i  (upper_in_i),
    .precision_i (precision_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .lower_out_o (lower_out_o),
    .upper_out_o (upper_out_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ bench/tb.sv @@
// self-checking testbench for axis_range_rounding_top: directed and random data ranges
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = arr_pkg::VW;
  localparam int PW          = arr_pkg::PW;
  localparam int FRAC_DIGITS = arr_pkg::FRAC_DIGITS;

  localparam longint POS_MAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam longint NEG_MIN = -(64'sd1 <<< (VW - 1));
  localparam int RANDOM_ITEMS = 1930;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic [PW-1:0]        prec;
  } range_item_t;

  typedef struct {
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 sat;
  } axis_bounds_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [VW-1:0] lower_in_i = '0;
  logic signed [VW-1:0] upper_in_i = '0;
  logic [PW-1:0]        precision_i = '0;
  logic                 out_valid_o;
  logic signed [VW-1:0] lower_out_o;
  logic signed [VW-1:0] upper_out_o;
  logic                 saturated_o;

  range_item_t  pending_items[$];
  axis_bounds_t expected_bounds[$];
  int           failures = 0;
  int           items_sent = 0;
  int           results_seen = 0;
  int           sat_seen = 0;
  int           zero_bounds = 0;

  axis_range_rounding_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .lower_in_i (lower_in_i),
    .upper_in_i (upper_in_i),
    .precision_i(precision_i),
    .out_valid_o(out_valid_o),
    .lower_out_o(lower_out_o),
    .upper_out_o(upper_out_o),
    .saturated_o(saturated_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint pow10(int e);
    longint r = 1;
    for (int i = 0; i < e; i++) r = r * 10;
    return r;
  endfunction

  // coarsest decade at which margined and raw quotients still differ
  function automatic int align_decade(longint t, longint l);
    int best = 1;
    for (int k = 1; k < 19; k++) begin
      if (t / pow10(k) == l / pow10(k)) return best;
      best = k;
    end
    return best;
  endfunction

  // returns {clamped, value} rescaled to the input format
  function automatic logic [VW:0] scale_to_input(logic neg, longint unsigned mag,
                                                 longint unsigned s);
    longint unsigned lim = neg ? longint'(-NEG_MIN) : longint'(POS_MAX);
    longint unsigned r;
    logic clamped = 1'b0;
    if (mag > lim / s) begin
      clamped = 1'b1;
      r = lim;
    end else begin
      r = mag * s;
    end
    if (neg) r = -r;
    return {clamped, r[VW-1:0]};
  endfunction

  function automatic axis_bounds_t predict_bounds(range_item_t it);
    int           p;
    longint       down, lmin, lmax, off, tmin, tmax, unit, q;
    longint       lo_v, hi_v;
    logic         neg;
    logic [VW:0]  r;
    axis_bounds_t res;
    p = (it.prec > FRAC_DIGITS) ? FRAC_DIGITS : int'(it.prec);
    down = pow10(FRAC_DIGITS - p);
    lo_v = it.lo;
    hi_v = it.hi;
    lmin = lo_v / down;
    lmax = hi_v / down;
    off = (lmax - lmin) / 10;
    tmin = lmin - off;
    tmax = lmax + off;
    res.sat = 1'b0;
    if (tmin <= 0 && lmin >= 0) begin
      res.lo = '0;
    end else begin
      unit = pow10(align_decade(tmin, lmin));
      q = lmin / unit;
      neg = lmin < 0;
      r = scale_to_input(neg, neg ? (1 - q) * unit : q * unit, down);
      res.lo = r[VW-1:0];
      res.sat |= r[VW];
    end
    if (lmax <= 0 && tmax >= 0) begin
      res.hi = '0;
    end else begin
      unit = pow10(align_decade(tmax, lmax));
      q = lmax / unit;
      neg = lmax <= 0;
      r = scale_to_input(neg, neg ? -q * unit : (q + 1) * unit, down);
      res.hi = r[VW-1:0];
      res.sat |= r[VW];
    end
    return res;
  endfunction

  function automatic longint clamp_value(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < NEG_MIN) return NEG_MIN;
    return v;
  endfunction

  function automatic longint rand_mag();
    longint unsigned u = {$urandom, $urandom};
    return longint'(u % longint'(pow10($urandom_range(0, 15)) + 1));
  endfunction

  function automatic longint rand_signed();
    longint m = rand_mag();
    return clamp_value($urandom_range(0, 1) ? -m : m);
  endfunction

  task automatic add_item(longint lo, longint hi, int prec);
    range_item_t it;
    it.lo = lo[VW-1:0];
    it.hi = hi[VW-1:0];
    it.prec = prec[PW-1:0];
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  always @(posedge clk_i) begin : drive_proc
    int   gap;
    int   steady;
    logic nstart;
    if (rst_ni) begin
      nstart = start;
      if (start && !busy) begin
        expected_bounds.insert(expected_bounds.size(),
                               predict_bounds(pending_items.pop_front()));
        items_sent++;
        nstart = 1'b0;
        if (steady > 0) begin
          steady--;
          gap = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) steady = 30;
          gap = pick_gap();
        end
      end
      if (!nstart) begin
        if (gap > 0 || pending_items.size() == 0) begin
          if (gap > 0) gap--;
          lower_in_i  <= VW'({$urandom, $urandom});
          upper_in_i  <= VW'({$urandom, $urandom});
          precision_i <= PW'($urandom);
        end else begin
          lower_in_i  <= pending_items[0].lo;
          upper_in_i  <= pending_items[0].hi;
          precision_i <= pending_items[0].prec;
          nstart = 1'b1;
        end
      end
      start <= nstart;
    end else begin
      gap = 0;
      steady = 0;
    end
  end

  always @(posedge clk_i) begin : check_proc
    axis_bounds_t want;
    if (rst_ni && out_valid_o) begin
      if (expected_bounds.size() == 0) begin
        $display("%0t: unexpected result lower %0d upper %0d saturated %0b",
                 $time, lower_out_o, upper_out_o, saturated_o);
        failures++;
      end else begin
        want = expected_bounds.pop_front();
        results_seen++;
        if (saturated_o) sat_seen++;
        if (lower_out_o == 0) zero_bounds++;
        if (upper_out_o == 0) zero_bounds++;
        if (lower_out_o !== want.lo) begin
          $display("%0t: lower_out expected %0d got %0d", $time, want.lo, lower_out_o);
          failures++;
        end
        if (upper_out_o !== want.hi) begin
          $display("%0t: upper_out expected %0d got %0d", $time, want.hi, upper_out_o);
          failures++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.sat, saturated_o);
          failures++;
        end
      end
    end
  end

  initial begin : stim_proc
    longint lo, hi;
    int     mode;
    add_item(0, 0, 0);
    add_item(POS_MAX, POS_MAX, 0);
    add_item(NEG_MIN, NEG_MIN, 6);
    add_item(NEG_MIN, POS_MAX, 3);
    add_item(POS_MAX, NEG_MIN, 0);
    add_item(1_500000, 9_800000, 1);
    add_item(100000, 9_000000, 2);
    add_item(-9_000000, -100000, 2);
    add_item(-5_250000, 7_750000, 4);
    add_item(123456789, 123456789, 6);
    add_item(42, 43, 7);
    add_item(-1, 1, 6);
    add_item(3_000000, -2_000000, 2);
    add_item(POS_MAX - 1_000000, POS_MAX, 6);
    add_item(NEG_MIN, NEG_MIN + 1000, 6);
    add_item(999999, 1000001, 5);
    add_item(0, 140737_488355, 0);
    add_item(-1, 0, 0);
    add_item(999999999, 1000000000, 3);
    add_item(-987654_321098, 123456_789012, 7);
    add_item(POS_MAX, POS_MAX, 6);
    add_item(NEG_MIN, NEG_MIN, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1: begin
          lo = longint'({$urandom, $urandom});
          hi = longint'({$urandom, $urandom});
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            hi = POS_MAX - $urandom_range(0, 5000000);
            lo = clamp_value(hi - rand_mag());
          end else begin
            lo = NEG_MIN + $urandom_range(0, 5000000);
            hi = clamp_value(lo + rand_mag());
          end
        end
        8: begin
          lo = rand_signed();
          hi = clamp_value(lo - rand_mag());
        end
        9: begin
          lo = longint'($urandom_range(0, 4000)) - 2000;
          hi = longint'($urandom_range(0, 4000)) - 2000;
        end
        default: begin
          lo = rand_signed();
          hi = clamp_value(lo + rand_mag());
        end
      endcase
      add_item(lo, hi, $urandom_range(0, 7));
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_items.size() != 0 || expected_bounds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ran %0d ranges (extremes, inverted, zero-crossing, random), %0d checked",
             items_sent, results_seen);
    $display("%0d results saturated, %0d bounds forced or rounded to zero", sat_seen, zero_bounds);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #30ms;
    $display("timeout with %0d items waiting", pending_items.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/arr_pkg.sv
rtl/arr_div10.sv
rtl/arr_dp.sv
rtl/arr_ctrl.sv
rtl/axis_range_rounding_top.sv
bench/tb.sv
